FILE: src/ntc_thermistor_temperature_unit_assert.svh
// ----------------------------------------------------------------------------
// NTC temperature unit assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef NTC_THERMISTOR_TEMPERATURE_UNIT_ASSERT_SVH
`define NTC_THERMISTOR_TEMPERATURE_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define NTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ntc assertion failed");
// next-cycle implication
`define NTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ntc assertion failed");
`else
`define NTC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define NTC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/ntc_pkg.sv
// ----------------------------------------------------------------------------
// NTC temperature package
// Widths, constants, codes and shared types of the NTC temperature unit.
// ----------------------------------------------------------------------------
package ntc_pkg;

    localparam int ADC_BITS_DEF = 12;
    localparam int CFG_W        = 16;
    localparam int REG_IDX_W    = 2;

    // log2 unit
    localparam int LOG_X_W    = 32;
    localparam int INT_W      = 5;
    localparam int FRAC_BITS  = 16;
    localparam int NORM_STEPS = 5;
    localparam int LOG_W      = INT_W + FRAC_BITS;

    // temperature datapath
    localparam int DEN_W = 42;
    localparam int NUM_W = 56;
    localparam int TC_W  = 16;

    localparam logic [31:0]     LN2_Q32       = 32'd2977044472;
    localparam logic [TC_W-1:0] ZERO_C_CENTIK = 16'd27315;
    localparam logic [TC_W-1:0] TEMP_MAX      = 16'd32767;
    localparam logic [TC_W-1:0] TC_MAX        = 16'd60082;
    localparam logic [23:0]     RES_MAX       = 24'hFFFFFF;

    // reset values of the registers
    localparam logic [CFG_W-1:0] PULLUP_RST   = 16'd9900;
    localparam logic [CFG_W-1:0] REF_RES_RST  = 16'd9090;
    localparam logic [CFG_W-1:0] BETA_RST     = 16'd3950;
    localparam logic [CFG_W-1:0] REF_TEMP_RST = 16'd29415;

    // fault codes
    localparam logic [1:0] FAULT_OK   = 2'd0;
    localparam logic [1:0] FAULT_ZERO = 2'd1;
    localparam logic [1:0] FAULT_SAT  = 2'd2;
    localparam logic [1:0] FAULT_RSVD = 2'd3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PULLUP,
        REG_REF_RES,
        REG_BETA,
        REG_REF_TEMP
    } t_reg_idx;

    typedef struct packed {
        logic den_pos;
        logic ovf;
    } t_temp_stat;

endpackage

FILE: src/ntc_rdiv.sv
// ----------------------------------------------------------------------------
// NTC resistance divider
// Restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module ntc_rdiv import ntc_pkg::*; #(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic                    i_zero,
    input  logic [CFG_W+ADC_BITS-1:0] i_num,
    input  logic [ADC_BITS-1:0]     i_div,
    output logic                    o_valid,
    output logic                    o_zero,
    output logic [CFG_W+ADC_BITS-1:0] o_quo
);

    localparam int QW = CFG_W + ADC_BITS;
    localparam int DW = ADC_BITS;

    logic [QW-1:0] r_num [QW];
    logic [QW-1:0] n_num [QW];
    logic [QW-1:0] r_quo [QW];
    logic [QW-1:0] n_quo [QW];
    logic [DW-1:0] r_rem [QW];
    logic [DW-1:0] n_rem [QW];
    logic [DW-1:0] r_div [QW];
    logic [DW-1:0] n_div [QW];
    logic [QW-1:0] r_v;
    logic [QW-1:0] r_z;

    // compute one quotient bit in every stage
    always_comb begin
        logic [QW-1:0] num;
        logic [QW-1:0] quo;
        logic [DW-1:0] rem;
        logic [DW-1:0] dv;
        logic [DW:0]   t;
        logic          ge;
        for (int s = 0; s < QW; s++) begin
            if (s == 0) begin
                num = i_num;
                quo = '0;
                rem = '0;
                dv  = i_div;
            end else begin
                num = r_num[s-1];
                quo = r_quo[s-1];
                rem = r_rem[s-1];
                dv  = r_div[s-1];
            end
            t  = {rem, num[QW-1]};
            ge = t >= {1'b0, dv};
            n_num[s] = num << 1;
            n_quo[s] = {quo[QW-2:0], ge};
            n_rem[s] = ge ? DW'(t - {1'b0, dv}) : t[DW-1:0];
            n_div[s] = dv;
        end
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QW-2:0], i_valid};
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z <= {r_z[QW-2:0], i_zero};
            for (int s = 0; s < QW; s++) begin
                r_num[s] <= n_num[s];
                r_quo[s] <= n_quo[s];
                r_rem[s] <= n_rem[s];
                r_div[s] <= n_div[s];
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_zero  = r_z[QW-1];
    assign o_quo   = r_quo[QW-1];

endmodule

FILE: src/ntc_log2.sv
// ----------------------------------------------------------------------------
// NTC log2 unit
// Two-lane Q16 log2: staged normalizer, then one squaring step per stage.
// ----------------------------------------------------------------------------
module ntc_log2 import ntc_pkg::*; #(
    parameter int SIDE_W = 30
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [LOG_X_W-1:0] i_xa,
    input  logic [LOG_X_W-1:0] i_xb,
    input  logic [SIDE_W-1:0]  i_side,
    output logic               o_valid,
    output logic [LOG_W-1:0]   o_la,
    output logic [LOG_W-1:0]   o_lb,
    output logic [SIDE_W-1:0]  o_side
);

    localparam int STAGES = NORM_STEPS + FRAC_BITS;
    localparam int YW     = LOG_X_W - 1;

    logic [LOG_X_W-1:0]   r_nx [NORM_STEPS][2];
    logic [LOG_X_W-1:0]   n_nx [NORM_STEPS][2];
    logic [INT_W-1:0]     r_lz [NORM_STEPS][2];
    logic [INT_W-1:0]     n_lz [NORM_STEPS][2];
    logic [YW-1:0]        r_y  [FRAC_BITS][2];
    logic [YW-1:0]        n_y  [FRAC_BITS][2];
    logic [INT_W-1:0]     r_n  [FRAC_BITS][2];
    logic [INT_W-1:0]     n_n  [FRAC_BITS][2];
    logic [FRAC_BITS-1:0] r_f  [FRAC_BITS][2];
    logic [FRAC_BITS-1:0] n_f  [FRAC_BITS][2];
    logic [STAGES-1:0]    r_v;
    logic [SIDE_W-1:0]    r_side [STAGES];

    // normalize: binary search for the top set bit
    always_comb begin
        logic [LOG_X_W-1:0] x;
        logic [INT_W-1:0]   lz;
        int                 sh;
        for (int k = 0; k < NORM_STEPS; k++) begin
            for (int ln = 0; ln < 2; ln++) begin
                if (k == 0) begin
                    x  = (ln == 0) ? i_xa : i_xb;
                    lz = '0;
                end else begin
                    x  = r_nx[k-1][ln];
                    lz = r_lz[k-1][ln];
                end
                sh = (LOG_X_W / 2) >> k;
                if ((x >> (LOG_X_W - sh)) == '0) begin
                    n_nx[k][ln] = x << sh;
                    n_lz[k][ln] = lz + INT_W'(sh);
                end else begin
                    n_nx[k][ln] = x;
                    n_lz[k][ln] = lz;
                end
            end
        end
    end

    // square the mantissa, one fraction bit per stage
    always_comb begin
        logic [YW-1:0]        y;
        logic [INT_W-1:0]     nn;
        logic [FRAC_BITS-1:0] f;
        logic [2*YW-1:0]      p;
        logic [LOG_X_W-1:0]   t;
        for (int j = 0; j < FRAC_BITS; j++) begin
            for (int ln = 0; ln < 2; ln++) begin
                if (j == 0) begin
                    y  = r_nx[NORM_STEPS-1][ln][LOG_X_W-1:1];
                    nn = ~r_lz[NORM_STEPS-1][ln];
                    f  = '0;
                end else begin
                    y  = r_y[j-1][ln];
                    nn = r_n[j-1][ln];
                    f  = r_f[j-1][ln];
                end
                p = (2*YW)'(y) * (2*YW)'(y);
                t = p[2*YW-1:YW-1];
                n_y[j][ln] = t[LOG_X_W-1] ? t[LOG_X_W-1:1] : t[YW-1:0];
                n_n[j][ln] = nn;
                n_f[j][ln] = {f[FRAC_BITS-2:0], t[LOG_X_W-1]};
            end
        end
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STAGES-2:0], i_valid};
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int s = 1; s < STAGES; s++) begin
                r_side[s] <= r_side[s-1];
            end
            r_nx <= n_nx;
            r_lz <= n_lz;
            r_y  <= n_y;
            r_n  <= n_n;
            r_f  <= n_f;
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_side  = r_side[STAGES-1];
    assign o_la    = {r_n[FRAC_BITS-1][0], r_f[FRAC_BITS-1][0]};
    assign o_lb    = {r_n[FRAC_BITS-1][1], r_f[FRAC_BITS-1][1]};

endmodule

FILE: src/ntc_temp.sv
// ----------------------------------------------------------------------------
// NTC temperature stage
// Log ratio to natural log, beta-equation denominator, pipelined division.
// ----------------------------------------------------------------------------
module ntc_temp import ntc_pkg::*; #(
    parameter int SIDE_W = 30
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [LOG_W-1:0]  i_la,
    input  logic [LOG_W-1:0]  i_lb,
    input  logic [SIDE_W-1:0] i_side,
    input  logic [CFG_W-1:0]  i_beta,
    input  logic [CFG_W-1:0]  i_t0,
    output logic              o_valid,
    output logic [SIDE_W-1:0] o_side,
    output logic [TC_W-1:0]   o_tc,
    output t_temp_stat        o_stat
);

    localparam int FRONT  = 6;
    localparam int STAGES = FRONT + TC_W;
    localparam int MAG_W  = LOG_W;
    localparam int PROD_W = MAG_W + 32;
    localparam int L_W    = LOG_W + 1;
    localparam int LT_W   = L_W + CFG_W + 1;
    localparam int BT_W   = 2 * CFG_W;
    localparam int NUMC_W = BT_W + 7 + 16;
    localparam int BD_W   = CFG_W + 7 + 16;
    localparam int RW     = DEN_W - 1;

    // constants derived from the registers
    logic [BT_W-1:0]   r_bt;
    logic [NUMC_W-1:0] r_num;
    logic [BD_W-1:0]   r_bden;

    logic [STAGES-1:0] r_v;
    logic [SIDE_W-1:0] r_side [STAGES];

    logic                    r1_neg;
    logic [MAG_W-1:0]        r1_mag;
    logic                    r2_neg;
    logic [PROD_W-1:0]       r2_prod;
    logic signed [L_W-1:0]   r3_l;
    logic signed [LT_W-1:0]  r4_lt;
    logic signed [DEN_W-1:0] r5_den;
    logic [RW-1:0]           r6_rem;
    logic [TC_W-1:0]         r6_low;
    logic [RW-1:0]           r6_den;
    t_temp_stat              r6_stat;

    logic [RW-1:0]   r_q_rem  [TC_W];
    logic [RW-1:0]   n_q_rem  [TC_W];
    logic [TC_W-1:0] r_q_low  [TC_W];
    logic [TC_W-1:0] n_q_low  [TC_W];
    logic [TC_W-1:0] r_q_quo  [TC_W];
    logic [TC_W-1:0] n_q_quo  [TC_W];
    logic [RW-1:0]   r_q_den  [TC_W];
    logic [RW-1:0]   n_q_den  [TC_W];
    t_temp_stat      r_q_stat [TC_W];
    t_temp_stat      n_q_stat [TC_W];

    logic signed [L_W-1:0]   c_d;
    logic [MAG_W-1:0]        c_q;
    logic signed [DEN_W-1:0] c_den;
    logic [NUM_W-1:0]        c_numr;

    // track register values
    always_ff @(posedge i_clk) begin
        r_bt   <= BT_W'(i_beta) * BT_W'(i_t0);
        r_num  <= (NUMC_W'(r_bt) * NUMC_W'(100)) << 16;
        r_bden <= {(CFG_W + 7)'(i_beta) * (CFG_W + 7)'(100), 16'b0};
    end

    // front combinational terms
    assign c_d    = $signed({1'b0, i_la}) - $signed({1'b0, i_lb});
    assign c_q    = MAG_W'((r2_prod + PROD_W'(64'h8000_0000)) >> 32);
    assign c_den  = $signed({{(DEN_W - BD_W){1'b0}}, r_bden})
                  + $signed({{(DEN_W - LT_W){r4_lt[LT_W-1]}}, r4_lt});
    assign c_numr = NUM_W'(r_num) + NUM_W'(r5_den[DEN_W-1:1]);

    // restoring division, one quotient bit per stage
    always_comb begin
        logic [RW-1:0]   rem;
        logic [TC_W-1:0] low;
        logic [TC_W-1:0] quo;
        logic [RW-1:0]   dn;
        t_temp_stat      st;
        logic [RW:0]     t;
        logic            ge;
        for (int j = 0; j < TC_W; j++) begin
            if (j == 0) begin
                rem = r6_rem;
                low = r6_low;
                quo = '0;
                dn  = r6_den;
                st  = r6_stat;
            end else begin
                rem = r_q_rem[j-1];
                low = r_q_low[j-1];
                quo = r_q_quo[j-1];
                dn  = r_q_den[j-1];
                st  = r_q_stat[j-1];
            end
            t  = {rem, low[TC_W-1]};
            ge = t >= {1'b0, dn};
            n_q_rem[j]  = ge ? RW'(t - {1'b0, dn}) : t[RW-1:0];
            n_q_low[j]  = low << 1;
            n_q_quo[j]  = {quo[TC_W-2:0], ge};
            n_q_den[j]  = dn;
            n_q_stat[j] = st;
        end
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STAGES-2:0], i_valid};
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int s = 1; s < STAGES; s++) begin
                r_side[s] <= r_side[s-1];
            end
            // log ratio magnitude and sign
            r1_neg  <= c_d[L_W-1];
            r1_mag  <= c_d[L_W-1] ? MAG_W'(-c_d) : MAG_W'(c_d);
            // scale by ln 2
            r2_neg  <= r1_neg;
            r2_prod <= PROD_W'(r1_mag) * PROD_W'(LN2_Q32);
            // round half away from zero
            r3_l    <= r2_neg ? -$signed({1'b0, c_q}) : $signed({1'b0, c_q});
            r4_lt   <= r3_l * $signed({1'b0, i_t0});
            r5_den  <= c_den;
            // seed the division with the rounded numerator
            r6_rem          <= RW'(c_numr[NUM_W-1:TC_W]);
            r6_low          <= c_numr[TC_W-1:0];
            r6_den          <= r5_den[RW-1:0];
            r6_stat.den_pos <= !r5_den[DEN_W-1] && (r5_den != '0);
            r6_stat.ovf     <= RW'(c_numr[NUM_W-1:TC_W]) >= r5_den[RW-1:0];
            r_q_rem  <= n_q_rem;
            r_q_low  <= n_q_low;
            r_q_quo  <= n_q_quo;
            r_q_den  <= n_q_den;
            r_q_stat <= n_q_stat;
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_side  = r_side[STAGES-1];
    assign o_tc    = r_q_quo[TC_W-1];
    assign o_stat  = r_q_stat[TC_W-1];

endmodule

FILE: src/ntc_thermistor_temperature_unit.sv
// ----------------------------------------------------------------------------
// NTC thermistor temperature unit
// Divider reading to thermistor resistance and beta-equation temperature.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  input    in         i_valid / o_stall  i_adc_code
//  output   out        o_valid / i_stall  o_resistance_ohms, o_temperature_centi_c,
//                                         o_fault
//  config   in         i_cfg_we           i_cfg_idx, i_cfg_data
//
//  One item enters every cycle while o_stall is low; the pipeline runs through the
//  one-bit-per-stage resistance divider, the 21-stage log2 unit and
//  the 16-stage temperature divider.
//  Reset clears the valid bits and loads the register defaults.
//  A held output freezes the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module ntc_thermistor_temperature_unit import ntc_pkg::*; #(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [ADC_BITS-1:0]  i_adc_code,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [23:0]          o_resistance_ohms,
    output logic signed [15:0]   o_temperature_centi_c,
    output logic [1:0]           o_fault,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    `include "ntc_thermistor_temperature_unit_assert.svh"

    localparam int QW     = CFG_W + ADC_BITS;
    localparam int SIDE_W = QW + 2;
    localparam logic [ADC_BITS:0] FULL_SCALE = (ADC_BITS + 1)'(1) << ADC_BITS;

    logic [CFG_W-1:0] r_pullup;
    logic [CFG_W-1:0] r_ref_res;
    logic [CFG_W-1:0] r_beta;
    logic [CFG_W-1:0] r_ref_temp;

    logic                r_in_v;
    logic                r_in_zero;
    logic [QW-1:0]       r_in_num;
    logic [ADC_BITS-1:0] r_in_div;

    logic                r_out_v;
    logic [23:0]         r_res;
    logic [15:0]         r_temp;
    logic [1:0]          r_fault;

    logic                en;
    logic [ADC_BITS:0]   c_div_full;
    logic                d_valid;
    logic                d_zero;
    logic [QW-1:0]       d_quo;
    logic [CFG_W-1:0]    c_r0;
    logic                l_valid;
    logic [LOG_W-1:0]    l_la;
    logic [LOG_W-1:0]    l_lb;
    logic [SIDE_W-1:0]   l_side;
    logic                t_valid;
    logic [SIDE_W-1:0]   t_side;
    logic [TC_W-1:0]     t_tc;
    t_temp_stat          t_stat;

    logic                c_zero;
    logic                c_rzero;
    logic [QW-1:0]       c_r;
    logic                c_big;
    logic                c_tsat;
    logic [23:0]         n_res;
    logic [15:0]         n_temp;
    logic [1:0]          n_fault;

    // freeze the pipeline while a result waits
    assign en      = !r_out_v || !i_stall;
    assign o_stall = !en;

    // write registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pullup   <= PULLUP_RST;
            r_ref_res  <= REF_RES_RST;
            r_beta     <= BETA_RST;
            r_ref_temp <= REF_TEMP_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_PULLUP:   r_pullup   <= i_cfg_data;
                REG_REF_RES:  r_ref_res  <= i_cfg_data;
                REG_BETA:     r_beta     <= i_cfg_data;
                REG_REF_TEMP: r_ref_temp <= i_cfg_data;
                default:      r_pullup   <= r_pullup;
            endcase
        end
    end

    // capture the sample: divider numerator and full-scale remainder
    assign c_div_full = FULL_SCALE - {1'b0, i_adc_code};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (en) begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_zero <= (i_adc_code == '0);
            r_in_num  <= QW'(r_pullup) * QW'(i_adc_code);
            r_in_div  <= c_div_full[ADC_BITS-1:0];
        end
    end

    ntc_rdiv #(
        .ADC_BITS (ADC_BITS)
    ) u_rdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_in_v),
        .i_zero  (r_in_zero),
        .i_num   (r_in_num),
        .i_div   (r_in_div),
        .o_valid (d_valid),
        .o_zero  (d_zero),
        .o_quo   (d_quo)
    );

    // a zero reference resistance counts as one ohm
    assign c_r0 = (r_ref_res == '0) ? CFG_W'(1) : r_ref_res;

    ntc_log2 #(
        .SIDE_W (SIDE_W)
    ) u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d_valid),
        .i_xa    (LOG_X_W'(d_quo)),
        .i_xb    (LOG_X_W'(c_r0)),
        .i_side  ({d_zero, (d_quo == '0), d_quo}),
        .o_valid (l_valid),
        .o_la    (l_la),
        .o_lb    (l_lb),
        .o_side  (l_side)
    );

    ntc_temp #(
        .SIDE_W (SIDE_W)
    ) u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (l_valid),
        .i_la    (l_la),
        .i_lb    (l_lb),
        .i_side  (l_side),
        .i_beta  (r_beta),
        .i_t0    (r_ref_temp),
        .o_valid (t_valid),
        .o_side  (t_side),
        .o_tc    (t_tc),
        .o_stat  (t_stat)
    );

    // pick the result and fault code
    assign c_zero  = t_side[SIDE_W-1];
    assign c_rzero = t_side[SIDE_W-2];
    assign c_r     = t_side[QW-1:0];
    assign c_big   = 32'(c_r) > 32'(RES_MAX);
    assign c_tsat  = !t_stat.den_pos || t_stat.ovf || (t_tc > TC_MAX);

    always_comb begin
        priority if (c_zero) begin
            n_res   = '0;
            n_temp  = '0;
            n_fault = FAULT_ZERO;
        end else if (c_rzero) begin
            n_res   = '0;
            n_temp  = 16'(-ZERO_C_CENTIK);
            n_fault = FAULT_SAT;
        end else begin
            n_res   = c_big ? RES_MAX : 24'(c_r);
            n_temp  = c_tsat ? TEMP_MAX : 16'(t_tc - ZERO_C_CENTIK);
            n_fault = (c_big || c_tsat) ? FAULT_SAT : FAULT_OK;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= t_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res   <= n_res;
            r_temp  <= n_temp;
            r_fault <= n_fault;
        end
    end

    assign o_valid               = r_out_v;
    assign o_resistance_ohms     = r_res;
    assign o_temperature_centi_c = $signed(r_temp);
    assign o_fault               = r_fault;

    `NTC_ASSERT_IMP(a_zero_code_clears, i_clk, i_rst_n, o_valid && (o_fault == FAULT_ZERO), (o_resistance_ohms == '0) && (o_temperature_centi_c == '0))
    `NTC_ASSERT_IMP(a_ok_has_res, i_clk, i_rst_n, o_valid && (o_fault == FAULT_OK), o_resistance_ohms != '0)
    `NTC_ASSERT_IMP(a_no_rsvd_fault, i_clk, i_rst_n, o_valid, o_fault != FAULT_RSVD)
    `NTC_ASSERT_NXT(a_drain, i_clk, i_rst_n, !i_stall && !t_valid, !o_valid)

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTC thermistor temperature unit testbench
// Drives ADC codes through the valid/stall channel under several register
// settings and idle patterns, predicts resistance, temperature and fault for
// every transfer, and checks each result in order against the prediction.
// ----------------------------------------------------------------------------
module testbench;
    import ntc_pkg::*;

    typedef struct packed {
        logic [23:0] res;
        logic [15:0] temp;
        logic [1:0]  fault;
    } t_reading;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 90;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [11:0]          i_adc_code;
    logic                 o_valid;
    logic                 i_stall;
    logic [23:0]          o_resistance_ohms;
    logic signed [15:0]   o_temperature_centi_c;
    logic [1:0]           o_fault;
    logic                 i_cfg_we;
    logic [REG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    // register copy used for prediction
    longint unsigned pullup_q, r0_q, beta_q, t0_q;

    logic [11:0] code_queue[$];
    t_reading    reading_queue[$];
    int          tx_idle_pct, rx_idle_pct;
    bit          hold_tx;
    int          mismatches;
    int          quiet_cycles;

    ntc_thermistor_temperature_unit DUT (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_adc_code            (i_adc_code),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_resistance_ohms     (o_resistance_ohms),
        .o_temperature_centi_c (o_temperature_centi_c),
        .o_fault               (o_fault),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // log2 in Q16: integer part from the top bit, fraction by 16 squarings
    function automatic longint unsigned log2_fixed(longint unsigned x);
        int              n;
        longint unsigned y;
        longint unsigned acc;
        n = 0;
        if (x == 0) x = 1;
        while (n < 63 && (x >> (n + 1)) != 0) n++;
        y   = (n <= 30) ? (x << (30 - n)) : (x >> (n - 30));
        acc = longint'(n) << 16;
        for (int i = 15; i >= 0; i--) begin
            y = (y * y) >> 30;
            if (y >= (64'd1 << 31)) begin
                y   = y >> 1;
                acc = acc | (64'd1 << i);
            end
        end
        return acc;
    endfunction

    // resistance, temperature and fault for one code under current registers
    function automatic t_reading convert_code(logic [11:0] adc);
        t_reading        rd;
        longint unsigned code, r, r0, mag, q, num, tc;
        longint          d, l, den, temp;
        code = adc;
        rd   = '0;
        if (code == 0) begin
            rd.fault = FAULT_ZERO;
            return rd;
        end
        r = (pullup_q * code) / (64'd4096 - code);
        if (r == 0) begin
            rd.temp  = -16'sd27315;
            rd.fault = FAULT_SAT;
            return rd;
        end
        rd.fault = FAULT_OK;
        if (r > 64'd16777215) begin
            rd.res   = RES_MAX;
            rd.fault = FAULT_SAT;
        end else begin
            rd.res = r[23:0];
        end
        r0  = (r0_q != 0) ? r0_q : 1;
        d   = longint'(log2_fixed(r)) - longint'(log2_fixed(r0));
        mag = longint'(d < 0 ? -d : d) * 64'd2977044472;
        q   = (mag + (64'd1 << 31)) >> 32;
        l   = (d < 0) ? -longint'(q) : longint'(q);
        num = 64'd100 * beta_q * t0_q * 64'd65536;
        den = longint'(64'd100 * beta_q * 64'd65536) + l * longint'(t0_q);
        if (den <= 0) begin
            temp     = 32767;
            rd.fault = FAULT_SAT;
        end else begin
            tc = (num + longint'(den) / 2) / longint'(den);
            if (tc > 64'd60082) begin
                temp     = 32767;
                rd.fault = FAULT_SAT;
            end else begin
                temp = longint'(tc) - 27315;
            end
        end
        rd.temp = temp[15:0];
        return rd;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", field, got, want);
        mismatches++;
    endtask

    // driver: predict on transfer, then present the next code or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            i_adc_code <= '0;
        end else begin
            if (i_valid && !o_stall) reading_queue.push_back(convert_code(i_adc_code));
            if (!i_valid || !o_stall) begin
                if (code_queue.size() > 0 && !hold_tx &&
                    $urandom_range(99) >= tx_idle_pct) begin
                    i_valid    <= 1'b1;
                    i_adc_code <= code_queue.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result transfer, then stall at random
    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (reading_queue.size() == 0) begin
                    report_mismatch("unexpected results", 1, 0);
                end else begin
                    want = reading_queue.pop_front();
                    if (o_resistance_ohms !== want.res)
                        report_mismatch("resistance", o_resistance_ohms, want.res);
                    if (o_temperature_centi_c !== $signed(want.temp))
                        report_mismatch("temperature", o_temperature_centi_c,
                                        $signed(want.temp));
                    if (o_fault !== want.fault)
                        report_mismatch("fault", o_fault, want.fault);
                end
            end
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // watchdog: end the run after too long without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // wait until nothing is queued, offered or outstanding, then drain
    task automatic wait_idle();
        do @(negedge i_clk);
        while (code_queue.size() != 0 || i_valid || reading_queue.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            REG_PULLUP:  pullup_q = value;
            REG_REF_RES: r0_q     = value;
            REG_BETA:    beta_q   = value;
            default:     t0_q     = value;
        endcase
    endtask

    task automatic load_regs(logic [15:0] pu, logic [15:0] r0, logic [15:0] b,
                             logic [15:0] t0);
        write_reg(REG_PULLUP, pu);
        write_reg(REG_REF_RES, r0);
        write_reg(REG_BETA, b);
        write_reg(REG_REF_TEMP, t0);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_random_codes(int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 4)       code_queue.push_back(12'd0);
            else if (pick < 12) code_queue.push_back(12'($urandom_range(15)));
            else if (pick < 20) code_queue.push_back(12'($urandom_range(4095, 4080)));
            else                code_queue.push_back(12'($urandom_range(4095)));
        end
    endtask

    // stimulus
    initial begin
        logic [11:0] directed[];
        directed    = '{12'd0, 12'd1, 12'd2, 12'd4095, 12'd4094, 12'd2048,
                        12'd1024, 12'd3000, 12'hAAA, 12'h555, 12'd100,
                        12'd3900, 12'd4000, 12'd7};
        pullup_q    = PULLUP_RST;
        r0_q        = REF_RES_RST;
        beta_q      = BETA_RST;
        t0_q        = REF_TEMP_RST;
        hold_tx     = 1'b0;
        mismatches  = 0;
        tx_idle_pct = 30;
        rx_idle_pct = 78;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = REG_PULLUP;
        i_cfg_data  = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 3) begin
                tx_idle_pct = 78;
                rx_idle_pct = 30;
            end else if (ph == 6) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (ph > 0) wait_idle();
            case (ph)
                0: ;
                1: load_regs(16'd65535, 16'd1, 16'd65535, 16'd65535);
                2: load_regs(16'd1, 16'd65535, 16'd1, 16'd1);
                3: load_regs(16'd4700, 16'd10000, 16'd3435, 16'd29815);
                4: load_regs(16'd0, 16'd0, 16'd0, 16'd0);
                5: load_regs(16'd65535, 16'd0, 16'd1, 16'd65535);
                6: load_regs(16'd9900, 16'd9090, 16'd3950, 16'd29415);
                default: load_regs(16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom));
            endcase
            if (ph == 0 || ph == 2) begin
                foreach (directed[i]) code_queue.push_back(directed[i]);
            end
            add_random_codes(170);
            if (ph == 1) begin
                // hold the sender until every result is back, then resume
                do @(negedge i_clk);
                while (code_queue.size() > 80);
                hold_tx = 1'b1;
                do @(negedge i_clk);
                while (i_valid || reading_queue.size() != 0);
                hold_tx = 1'b0;
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
